// ----- src/ptrs_pkg.sv -----
package ptrs_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int TIME_W   = 64;
  localparam int PERIOD_W = 32;
  localparam int TAG_W    = 16;
  localparam int PRIO_W   = 8;
  localparam int ENTRY_W  = TIME_W + PERIOD_W + TAG_W;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_FULL     = 2'd1,
    ST_RELEASED = 2'd2,
    ST_DONE     = 2'd3
  } status_t;

  // One task table word
  typedef struct packed {
    logic [TIME_W-1:0]   next_release;
    logic [PERIOD_W-1:0] period;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  // Insertion request to the priority order list
  typedef struct packed {
    logic              ins;
    logic [PRIO_W-1:0] prio;
    logic [IDX_W-1:0]  idx;
  } ord_cmd_t;

endpackage

// ----- src/ptrs_table_mem.sv -----
module ptrs_table_mem
  import ptrs_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/ptrs_order.sv -----
module ptrs_order
  import ptrs_pkg::*;
(
  input  logic             clk,
  input  ord_cmd_t         cmd,
  input  logic [CNT_W-1:0] count,
  input  logic [IDX_W-1:0] rd_pos,
  output logic [IDX_W-1:0] rd_idx
);

  // Table indices kept sorted by priority, ties in order of insertion
  logic [PRIO_W-1:0] sorted_prio [TABLE_DEPTH];
  logic [IDX_W-1:0]  sorted_idx  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] later;

  // Live positions holding a strictly higher priority value form a suffix
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      later[k] = (CNT_W'(k) < count) && (sorted_prio[k] > cmd.prio);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (later[0] || count == '0) begin
        sorted_prio[0] <= cmd.prio;
        sorted_idx[0]  <= cmd.idx;
      end
      for (int k = 1; k < TABLE_DEPTH; k++) begin
        if (later[k-1]) begin
          // shift up one place behind the new entry
          sorted_prio[k] <= sorted_prio[k-1];
          sorted_idx[k]  <= sorted_idx[k-1];
        end else if (later[k] || CNT_W'(k) == count) begin
          sorted_prio[k] <= cmd.prio;
          sorted_idx[k]  <= cmd.idx;
        end
      end
    end
  end

  assign rd_idx = sorted_idx[rd_pos];

endmodule

// ----- src/periodic_task_release_scheduler_unit.sv -----
// Channel  | Signals               | Payload
// ---------+-----------------------+----------------------------------------------
// s_axis   | tvalid tready tdata   | tuser: cmd; tdata: now_time, task_tag,
//          | tuser                 | period, prio_level
// m_axis   | tvalid tready tdata   | tuser: status; tdata: released_tag;
//          | tuser tlast           | tlast: last
//
// Clear, add and unknown commands answer from the output register in the cycle after they are accepted.
// In a step the scan reads one table word per cycle while it is not stalled, through
// the single read port of the task memory, in priority order.
// A due task held up by a busy output stalls the scan in place.
// Synchronous reset empties the table; the task memory itself is not cleared.
module periodic_task_release_scheduler_unit
  import ptrs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // now_time[63:0], task_tag[79:64],
                                      // period[111:80], prio_level[119:112]
  input  logic [1:0]   s_axis_tuser,  // cmd[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,  // released_tag[15:0]
  output logic [1:0]   m_axis_tuser,  // status[1:0]
  output logic         m_axis_tlast   // last
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t             state;
  logic [CNT_W-1:0]   task_count;
  logic [CNT_W-1:0]   scan_ptr;
  logic               chk_valid;
  logic [IDX_W-1:0]   chk_idx;
  logic [TIME_W-1:0]  now_reg;

  logic               out_valid;
  status_t            out_status;
  logic [TAG_W-1:0]   out_tag;
  logic               out_last;

  cmd_t               in_cmd;
  logic [TIME_W-1:0]  in_now;
  logic [TAG_W-1:0]   in_tag;
  logic [PERIOD_W-1:0] in_period;
  logic [PRIO_W-1:0]  in_prio;

  logic               in_xfer;
  logic               out_busy;
  logic               table_full;
  logic               due;
  logic               stall;
  logic               add_ok;
  logic               release_now;
  logic               scan_done;
  logic               out_load;

  ord_cmd_t           ord_cmd;
  logic [IDX_W-1:0]   ord_idx;

  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_addr;
  entry_t             mem_wr_data;
  logic [IDX_W-1:0]   mem_rd_addr;
  entry_t             mem_rd_data;

  assign in_cmd    = cmd_t'(s_axis_tuser);
  assign in_now    = s_axis_tdata[63:0];
  assign in_tag    = s_axis_tdata[79:64];
  assign in_period = s_axis_tdata[111:80];
  assign in_prio   = s_axis_tdata[119:112];

  assign out_busy      = out_valid && !m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !out_busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign table_full    = (task_count == CNT_W'(TABLE_DEPTH));
  assign add_ok        = in_xfer && (in_cmd == CMD_ADD) && !table_full;

  assign due         = (now_reg >= mem_rd_data.next_release);
  assign stall       = (state == S_SCAN) && chk_valid && due && out_busy;
  assign release_now = (state == S_SCAN) && chk_valid && due && !out_busy;
  assign scan_done   = (state == S_SCAN) && !chk_valid && (scan_ptr == task_count) &&
                       !out_busy;
  // load the output register with a fresh result
  assign out_load    = (in_xfer && in_cmd != CMD_STEP) || release_now || scan_done;

  assign ord_cmd.ins  = add_ok;
  assign ord_cmd.prio = in_prio;
  assign ord_cmd.idx  = task_count[IDX_W-1:0];

  ptrs_order u_order (
    .clk    (clk),
    .cmd    (ord_cmd),
    .count  (task_count),
    .rd_pos (scan_ptr[IDX_W-1:0]),
    .rd_idx (ord_idx)
  );

  always_comb begin
    mem_wr_en   = add_ok || release_now;
    mem_wr_addr = add_ok ? task_count[IDX_W-1:0] : chk_idx;
    if (add_ok) begin
      mem_wr_data.next_release = in_now;
      mem_wr_data.period       = in_period;
      mem_wr_data.tag          = in_tag;
    end else begin
      mem_wr_data.next_release = now_reg + TIME_W'(mem_rd_data.period);
      mem_wr_data.period       = mem_rd_data.period;
      mem_wr_data.tag          = mem_rd_data.tag;
    end
    // re-read the stalled entry so its word stays on the read port
    mem_rd_addr = stall ? chk_idx : ord_idx;
  end

  ptrs_table_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      task_count <= '0;
      scan_ptr   <= '0;
      chk_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            out_tag   <= '0;
            out_last  <= 1'b1;
            unique case (in_cmd)
              CMD_CLEAR: begin
                task_count <= '0;
                out_status <= ST_DONE;
              end
              CMD_ADD: begin
                if (table_full) begin
                  out_status <= ST_FULL;
                end else begin
                  task_count <= task_count + 1'b1;
                  out_status <= ST_ADDED;
                end
              end
              CMD_STEP: begin
                now_reg   <= in_now;
                scan_ptr  <= '0;
                chk_valid <= 1'b0;
                state     <= S_SCAN;
              end
              default: begin
                out_status <= ST_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!stall) begin
            if (release_now) begin
              out_status <= ST_RELEASED;
              out_tag    <= mem_rd_data.tag;
              out_last   <= 1'b0;
            end else if (scan_done) begin
              out_status <= ST_DONE;
              out_tag    <= '0;
              out_last   <= 1'b1;
              state      <= S_IDLE;
            end
            // advance the scan by one entry
            if (scan_ptr < task_count) begin
              chk_valid <= 1'b1;
              chk_idx   <= ord_idx;
              scan_ptr  <= scan_ptr + 1'b1;
            end else begin
              chk_valid <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_tag;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    task_count <= CNT_W'(TABLE_DEPTH))
    else $error("task count beyond table depth");

  a_step_enters_scan: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_cmd == CMD_STEP) |=> (state == S_SCAN && !m_axis_tvalid))
    else $error("step command did not start a scan");

  a_stall_holds_entry: assert property (@(posedge clk) disable iff (rst)
    stall |=> (chk_valid && $stable(chk_idx) && $stable(scan_ptr)))
    else $error("scan moved on while a release was held");

  a_release_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_RELEASED) |-> (!m_axis_tlast && state == S_SCAN))
    else $error("release result outside a scan or flagged last");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_ptr <= task_count))
    else $error("scan pointer past the live entries");
`endif

endmodule
